FILE: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the timed split crossfader
// Item opcodes, register indexes, the microcode word and the control program.
// ----------------------------------------------------------------------------
package tsc_pkg;

	// Fade scale and counter width
	localparam logic [7:0] FULL_LEVEL = 8'd255;
	localparam int COUNT_WIDTH = 16;
	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	// Divider datapath: numerator up to FULL*count, divisor shifted by up to 8
	localparam int DEN_W = 16;
	localparam int QUO_W = 9;
	localparam int DIV_W = (COUNT_WIDTH + 8 > DEN_W + QUO_W) ? COUNT_WIDTH + 8 : DEN_W + QUO_W;
	localparam int DCNT_W = 4;

	// Configuration register indexes
	localparam logic [1:0] REG_DELAY_IN = 2'd0;
	localparam logic [1:0] REG_DELAY_OUT = 2'd1;
	localparam logic [1:0] REG_FADE_IN = 2'd2;
	localparam logic [1:0] REG_FADE_OUT = 2'd3;

	// Item opcodes
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_CHAN = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_SET_X = 3'd3;
	localparam logic [2:0] OP_SET_Y = 3'd4;

	// Datapath micro-operations
	typedef enum logic [4:0] {
		UOP_NOP,
		UOP_TICK,
		UOP_LDX,
		UOP_LDY,
		UOP_DIV,
		UOP_WRX,
		UOP_WRY,
		UOP_DONE,
		UOP_LDCX,
		UOP_SVX,
		UOP_LDCY,
		UOP_CHFIN,
		UOP_CHTGT,
		UOP_START,
		UOP_SETX,
		UOP_SETY,
		UOP_EMIT
	} uop_t;

	// Sequencer branch conditions
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_OUT_IDLE,
		COND_IN_IDLE,
		COND_DIV_BUSY,
		COND_NOFADE,
		COND_END
	} cond_t;

	typedef logic [4:0] upc_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		upc_t  target;
	} ucode_t;

	// Program entry points
	localparam upc_t PC_TICK = 5'd0;
	localparam upc_t PC_CHAN = 5'd9;
	localparam upc_t PC_START = 5'd17;
	localparam upc_t PC_SETX = 5'd19;
	localparam upc_t PC_SETY = 5'd21;
	localparam upc_t PC_IDLE_OP = 5'd23;

	function automatic upc_t entry_pc(input logic [2:0] op);
		upc_t pc;
		unique case (op)
			OP_TICK:  pc = PC_TICK;
			OP_CHAN:  pc = PC_CHAN;
			OP_START: pc = PC_START;
			OP_SET_X: pc = PC_SETX;
			OP_SET_Y: pc = PC_SETY;
			default:  pc = PC_IDLE_OP;
		endcase
		return pc;
	endfunction

	// Control store
	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		unique case (pc)
			// tick: count delays, fade X, fade Y, test completion
			5'd0:    w = '{UOP_TICK,  COND_NEXT,     5'd0};
			5'd1:    w = '{UOP_LDX,   COND_OUT_IDLE, 5'd4};
			5'd2:    w = '{UOP_DIV,   COND_DIV_BUSY, 5'd2};
			5'd3:    w = '{UOP_WRX,   COND_NEXT,     5'd0};
			5'd4:    w = '{UOP_LDY,   COND_IN_IDLE,  5'd7};
			5'd5:    w = '{UOP_DIV,   COND_DIV_BUSY, 5'd5};
			5'd6:    w = '{UOP_WRY,   COND_NEXT,     5'd0};
			5'd7:    w = '{UOP_DONE,  COND_NEXT,     5'd0};
			5'd8:    w = '{UOP_EMIT,  COND_END,      5'd0};
			// channel: scale by X, scale by Y, take the larger
			5'd9:    w = '{UOP_LDCX,  COND_NOFADE,   5'd15};
			5'd10:   w = '{UOP_DIV,   COND_DIV_BUSY, 5'd10};
			5'd11:   w = '{UOP_SVX,   COND_NEXT,     5'd0};
			5'd12:   w = '{UOP_LDCY,  COND_NEXT,     5'd0};
			5'd13:   w = '{UOP_DIV,   COND_DIV_BUSY, 5'd13};
			5'd14:   w = '{UOP_CHFIN, COND_JUMP,     5'd16};
			5'd15:   w = '{UOP_CHTGT, COND_NEXT,     5'd0};
			5'd16:   w = '{UOP_EMIT,  COND_END,      5'd0};
			// start, manual levels, unused opcodes
			5'd17:   w = '{UOP_START, COND_NEXT,     5'd0};
			5'd18:   w = '{UOP_EMIT,  COND_END,      5'd0};
			5'd19:   w = '{UOP_SETX,  COND_NEXT,     5'd0};
			5'd20:   w = '{UOP_EMIT,  COND_END,      5'd0};
			5'd21:   w = '{UOP_SETY,  COND_NEXT,     5'd0};
			5'd22:   w = '{UOP_EMIT,  COND_END,      5'd0};
			default: w = '{UOP_EMIT,  COND_END,      5'd0};
		endcase
		return w;
	endfunction

	// Load a counter from a 16-bit register, saturating to the counter range
	function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [15:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0] : w[COUNT_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/timed_split_crossfade.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_split_crossfade: two-scene crossfader with split delay and fade times
//
// Channel   Signals                                   Direction
// in        in_valid/in_ready, opcode..no_fade        item into the fader
// out       out_valid/out_ready, channel_value..      one result per item
// cfg       psel/penable/pwrite/paddr/pwdata/prdata   register access, APB
//
// One item is processed at a time by a microcoded sequencer over a shared
// 9-step restoring divider. A tick runs one division for each fade that
// runs, a channel item runs two (none when it snaps to target); other items
// run none. Reset clears levels, counters and the finished flag; registers
// return to their defaults. A stalled result holds in the output register;
// the next item is still accepted and waits at its last step for the output
// to free up.
// ----------------------------------------------------------------------------
module timed_split_crossfade (
	input  wire         clk,
	input  wire         arst_n,
	// item channel
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  opcode,
	input  wire  [7:0]  level,
	input  wire  [7:0]  chan_min,
	input  wire  signed [8:0] delta_x,
	input  wire  signed [8:0] delta_y,
	input  wire  [7:0]  target,
	input  wire         no_fade,
	// result channel
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  channel_value,
	output logic [7:0]  level_x_out,
	output logic [7:0]  level_y_out,
	output logic        finished,
	output logic        release_res,
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = tsc_pkg::COUNT_WIDTH;
	localparam int DW = tsc_pkg::DIV_W;
	localparam int QW = tsc_pkg::QUO_W;

	// Configuration registers
	logic [15:0] cfg_delay_in_q, cfg_delay_out_q, cfg_fade_in_q, cfg_fade_out_q;

	// Captured item
	logic [7:0]        level_q, min_q, tgt_q;
	logic signed [8:0] dx_q, dy_q;
	logic              nofade_q;

	// Fader state
	logic [7:0]    x_q, y_q;
	logic [CW-1:0] in_dly_q, out_dly_q, in_fade_q, out_fade_q;
	logic          done_q, in_run_q, out_run_q;
	logic [7:0]    chan_q;
	logic          rel_q;
	logic signed [10:0] vx_q;

	// Divider
	logic [DW-1:0]                  div_rem_q, div_den_q;
	logic [QW-1:0]                  div_quo_q;
	logic [tsc_pkg::DCNT_W-1:0]     div_cnt_q;
	logic                           div_zero_q, div_sat_q, div_neg_q;

	// Sequencer
	logic            busy_q;
	tsc_pkg::upc_t   pc_q;
	tsc_pkg::ucode_t uw;
	tsc_pkg::uop_t   uop;
	logic            take_in, emit_go, jump;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_chan_q, out_x_q, out_y_q;
	logic       out_fin_q, out_rel_q;

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_delay_in_q <= 16'd0;
			cfg_delay_out_q <= 16'd0;
			cfg_fade_in_q <= 16'd1;
			cfg_fade_out_q <= 16'd1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				tsc_pkg::REG_DELAY_IN:  cfg_delay_in_q <= pwdata[15:0];
				tsc_pkg::REG_DELAY_OUT: cfg_delay_out_q <= pwdata[15:0];
				tsc_pkg::REG_FADE_IN:   cfg_fade_in_q <= pwdata[15:0];
				tsc_pkg::REG_FADE_OUT:  cfg_fade_out_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tsc_pkg::REG_DELAY_IN:  prdata = {16'd0, cfg_delay_in_q};
			tsc_pkg::REG_DELAY_OUT: prdata = {16'd0, cfg_delay_out_q};
			tsc_pkg::REG_FADE_IN:   prdata = {16'd0, cfg_fade_in_q};
			tsc_pkg::REG_FADE_OUT:  prdata = {16'd0, cfg_fade_out_q};
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: fetch control word, branch, hand off the result
	// ---------------------------------------------------------------------
	assign in_ready = !busy_q;
	assign take_in = in_valid && in_ready;
	assign uw = tsc_pkg::ucode_rom(pc_q);
	assign uop = busy_q ? uw.uop : tsc_pkg::UOP_NOP;
	assign emit_go = busy_q && (uw.uop == tsc_pkg::UOP_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (uw.cond)
			tsc_pkg::COND_NEXT:     jump = 1'b0;
			tsc_pkg::COND_JUMP:     jump = 1'b1;
			tsc_pkg::COND_OUT_IDLE: jump = !out_run_q;
			tsc_pkg::COND_IN_IDLE:  jump = !in_run_q;
			tsc_pkg::COND_DIV_BUSY: jump = (div_cnt_q != '0);
			tsc_pkg::COND_NOFADE:   jump = nofade_q;
			tsc_pkg::COND_END:      jump = 1'b0;
			default:                jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= '0;
		end else if (take_in) begin
			busy_q <= 1'b1;
			pc_q <= tsc_pkg::entry_pc(opcode);
		end else if (busy_q) begin
			if (uw.cond == tsc_pkg::COND_END) begin
				// hold at the last step until the output register frees up
				if (emit_go) begin
					busy_q <= 1'b0;
				end
			end else if (jump) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	// Capture the item fields
	always_ff @(posedge clk) begin
		if (take_in) begin
			level_q <= level;
			min_q <= chan_min;
			dx_q <= delta_x;
			dy_q <= delta_y;
			tgt_q <= target;
			nofade_q <= no_fade;
		end
	end

	// ---------------------------------------------------------------------
	// Shared divider: numerator/denominator selection and restoring steps
	// ---------------------------------------------------------------------
	logic [8:0]    mag_x, mag_y;
	logic [DW-1:0] ld_num;
	logic [15:0]   ld_den;
	logic          ld_neg, ld_go;
	logic [QW-1:0] q9;
	logic [7:0]    ratio8;
	logic          div_ge;

	assign mag_x = dx_q[8] ? (~dx_q + 9'd1) : dx_q;
	assign mag_y = dy_q[8] ? (~dy_q + 9'd1) : dy_q;

	always_comb begin
		ld_go = 1'b1;
		ld_neg = 1'b0;
		ld_num = '0;
		ld_den = 16'd0;
		unique case (uop)
			tsc_pkg::UOP_LDX: begin
				ld_num = DW'(out_fade_q) * DW'(tsc_pkg::FULL_LEVEL);
				ld_den = cfg_fade_out_q;
			end
			tsc_pkg::UOP_LDY: begin
				ld_num = DW'(in_fade_q) * DW'(tsc_pkg::FULL_LEVEL);
				ld_den = cfg_fade_in_q;
			end
			tsc_pkg::UOP_LDCX: begin
				ld_num = DW'(mag_x) * DW'(x_q);
				ld_den = 16'(tsc_pkg::FULL_LEVEL);
				ld_neg = dx_q[8];
			end
			tsc_pkg::UOP_LDCY: begin
				ld_num = DW'(mag_y) * DW'(y_q);
				ld_den = 16'(tsc_pkg::FULL_LEVEL);
				ld_neg = dy_q[8];
			end
			default: ld_go = 1'b0;
		endcase
	end

	assign div_ge = (div_rem_q >= div_den_q);

	always_ff @(posedge clk) begin
		if (ld_go) begin
			div_rem_q <= ld_num;
			div_den_q <= DW'(ld_den) << (QW - 1);
			div_quo_q <= '0;
			div_cnt_q <= tsc_pkg::DCNT_W'(QW - 1);
			div_zero_q <= (ld_den == 16'd0);
			div_sat_q <= (ld_num >= (DW'(ld_den) << QW));
			div_neg_q <= ld_neg;
		end else if (uop == tsc_pkg::UOP_DIV) begin
			if (div_ge) begin
				div_rem_q <= div_rem_q - div_den_q;
			end
			div_quo_q <= {div_quo_q[QW-2:0], div_ge};
			div_den_q <= div_den_q >> 1;
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// Quotient with divide-by-zero and overflow handling, fade ratio capped
	assign q9 = div_zero_q ? '0 : (div_sat_q ? '1 : div_quo_q);
	assign ratio8 = (q9 > QW'(tsc_pkg::FULL_LEVEL)) ? tsc_pkg::FULL_LEVEL : q9[7:0];

	// ---------------------------------------------------------------------
	// Channel arithmetic: signed quotient added to the channel base
	// ---------------------------------------------------------------------
	logic signed [10:0] qs, vsum, vmax;
	logic [7:0]         vsat;

	assign qs = div_neg_q ? -$signed({2'b00, q9}) : $signed({2'b00, q9});
	assign vsum = $signed({3'b000, min_q}) + qs;
	assign vmax = (vx_q > vsum) ? vx_q : vsum;
	always_comb begin
		priority if (vmax < 11'sd0) begin
			vsat = 8'd0;
		end else if (vmax > 11'sd255) begin
			vsat = 8'd255;
		end else begin
			vsat = vmax[7:0];
		end
	end

	// ---------------------------------------------------------------------
	// Fader state updates
	// ---------------------------------------------------------------------
	logic [CW-1:0] in_dly_nx, out_dly_nx;
	logic          in_run_nx, out_run_nx;

	assign in_dly_nx = (in_dly_q != '0) ? in_dly_q - 1'b1 : in_dly_q;
	assign out_dly_nx = (out_dly_q != '0) ? out_dly_q - 1'b1 : out_dly_q;
	assign in_run_nx = (in_dly_nx == '0) && (in_fade_q != '0);
	assign out_run_nx = (out_dly_nx == '0) && (out_fade_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= 8'd0;
			y_q <= 8'd0;
			in_dly_q <= '0;
			out_dly_q <= '0;
			in_fade_q <= '0;
			out_fade_q <= '0;
			done_q <= 1'b0;
			in_run_q <= 1'b0;
			out_run_q <= 1'b0;
			chan_q <= 8'd0;
			rel_q <= 1'b0;
			vx_q <= '0;
		end else if (take_in) begin
			// non-channel items report zero channel fields
			chan_q <= 8'd0;
			rel_q <= 1'b0;
		end else begin
			unique case (uop)
				tsc_pkg::UOP_TICK: begin
					in_dly_q <= in_dly_nx;
					out_dly_q <= out_dly_nx;
					in_run_q <= in_run_nx;
					out_run_q <= out_run_nx;
					if (in_run_nx) begin
						in_fade_q <= in_fade_q - 1'b1;
					end
					if (out_run_nx) begin
						out_fade_q <= out_fade_q - 1'b1;
					end
				end
				tsc_pkg::UOP_WRX: x_q <= ratio8;
				tsc_pkg::UOP_WRY: y_q <= tsc_pkg::FULL_LEVEL - ratio8;
				tsc_pkg::UOP_DONE: begin
					if (x_q == 8'd0 && y_q == tsc_pkg::FULL_LEVEL) begin
						done_q <= 1'b1;
					end
				end
				tsc_pkg::UOP_SVX: vx_q <= vsum;
				tsc_pkg::UOP_CHFIN: begin
					chan_q <= vsat;
					rel_q <= done_q;
				end
				tsc_pkg::UOP_CHTGT: begin
					chan_q <= tgt_q;
					rel_q <= done_q;
				end
				tsc_pkg::UOP_START: begin
					in_dly_q <= tsc_pkg::sat_count(cfg_delay_in_q);
					out_dly_q <= tsc_pkg::sat_count(cfg_delay_out_q);
					in_fade_q <= tsc_pkg::sat_count(cfg_fade_in_q);
					out_fade_q <= tsc_pkg::sat_count(cfg_fade_out_q);
					done_q <= 1'b0;
				end
				tsc_pkg::UOP_SETX: x_q <= level_q;
				tsc_pkg::UOP_SETY: y_q <= level_q;
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_chan_q <= chan_q;
			out_x_q <= x_q;
			out_y_q <= y_q;
			out_fin_q <= done_q;
			out_rel_q <= rel_q;
		end
	end

	assign out_valid = out_valid_q;
	assign channel_value = out_chan_q;
	assign level_x_out = out_x_q;
	assign level_y_out = out_y_q;
	assign finished = out_fin_q;
	assign release_res = out_rel_q;

endmodule
`default_nettype wire

FILE: rtl/tsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_checker: port-level checks of the timed split crossfader
// Watches the item and result channels and flags broken behavior.
// ----------------------------------------------------------------------------
module tsc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] channel_value,
	input wire [7:0] level_x_out,
	input wire [7:0] level_y_out,
	input wire       finished,
	input wire       release_res
);

	// Hold a stalled result transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel_value)
			&& $stable(level_x_out) && $stable(level_y_out) && $stable(finished)
			&& $stable(release_res))
		else $error("stalled result changed");

	// A released channel only comes from a finished fade
	a_rel_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && release_res |-> finished)
		else $error("release without finished");

	// One item in flight: no transfer right after an accepted item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// No result appears straight after an accepted item while the output is empty
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared with no processing cycle");

endmodule

bind timed_split_crossfade tsc_checker u_tsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.channel_value (channel_value),
	.level_x_out   (level_x_out),
	.level_y_out   (level_y_out),
	.finished      (finished),
	.release_res   (release_res)
);
`default_nettype wire

FILE: verif/tsc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_result_checker: result predictor and scoreboard for the crossfader
// Mirrors register writes from the configuration port and keeps its own copy
// of the levels, delay and fade counters and the finished flag. Predicts one
// result for every accepted item and compares results in order, field by field.
// ----------------------------------------------------------------------------
module tsc_result_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire  [2:0]        opcode,
	input  wire  [7:0]        level,
	input  wire  [7:0]        chan_min,
	input  wire  signed [8:0] delta_x,
	input  wire  signed [8:0] delta_y,
	input  wire  [7:0]        target,
	input  wire               no_fade,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire  [7:0]        channel_value,
	input  wire  [7:0]        level_x_out,
	input  wire  [7:0]        level_y_out,
	input  wire               finished,
	input  wire               release_res,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [3:0]        paddr,
	input  wire  [31:0]       pwdata,
	input  wire               pready,
	output int                mismatch_count,
	output int                results_due
);

	typedef struct packed {
		logic [7:0] chan;
		logic [7:0] lvl_x;
		logic [7:0] lvl_y;
		logic       fin;
		logic       rel;
	} fader_result_t;

	fader_result_t fader_results_due[$];
	fader_result_t seen, oldest, fresh;

	// Mirrored registers
	logic [15:0] cfg_delay_in, cfg_delay_out, cfg_fade_in, cfg_fade_out;

	// Mirrored fader state
	logic [7:0]                      lvl_x, lvl_y;
	logic [tsc_pkg::COUNT_WIDTH-1:0] in_wait, out_wait, in_left, out_left;
	logic                            fade_done;

	// FULL*remaining/total capped at full scale, zero for a zero total
	function automatic logic [8:0] fade_ratio(
			input logic [tsc_pkg::COUNT_WIDTH-1:0] remaining, input logic [15:0] total);
		longint q;
		if (total == 16'd0)
			return 9'd0;
		q = (longint'(tsc_pkg::FULL_LEVEL) * longint'(remaining)) / longint'(total);
		return (q > longint'(tsc_pkg::FULL_LEVEL)) ? 9'(tsc_pkg::FULL_LEVEL) : q[8:0];
	endfunction

	// Base plus span scaled by a level, quotient truncated toward zero
	function automatic int scaled_level(input logic [7:0] base, input logic signed [8:0] span,
			input logic [7:0] lvl);
		return int'(base) + (int'(span) * int'(lvl)) / int'(tsc_pkg::FULL_LEVEL);
	endfunction

	// Apply one item to the mirrored state and form its result
	task automatic advance_fader(output fader_result_t r);
		int vx, vy, v;
		r = '0;
		case (opcode)
			tsc_pkg::OP_TICK: begin
				if (in_wait > 0)
					in_wait--;
				if (out_wait > 0)
					out_wait--;
				if (out_wait == 0 && out_left > 0) begin
					out_left--;
					lvl_x = 8'(fade_ratio(out_left, cfg_fade_out));
				end
				if (in_wait == 0 && in_left > 0) begin
					in_left--;
					lvl_y = 8'(9'(tsc_pkg::FULL_LEVEL) - fade_ratio(in_left, cfg_fade_in));
				end
				if (lvl_x == 8'd0 && lvl_y == tsc_pkg::FULL_LEVEL)
					fade_done = 1'b1;
			end
			tsc_pkg::OP_CHAN: begin
				if (no_fade) begin
					r.chan = target;
				end else begin
					vx = scaled_level(chan_min, delta_x, lvl_x);
					vy = scaled_level(chan_min, delta_y, lvl_y);
					v = (vx > vy) ? vx : vy;
					if (v < 0)
						v = 0;
					if (v > 255)
						v = 255;
					r.chan = v[7:0];
				end
				r.rel = fade_done;
			end
			tsc_pkg::OP_START: begin
				in_wait = cfg_delay_in;
				out_wait = cfg_delay_out;
				in_left = cfg_fade_in;
				out_left = cfg_fade_out;
				fade_done = 1'b0;
			end
			tsc_pkg::OP_SET_X: lvl_x = level;
			tsc_pkg::OP_SET_Y: lvl_y = level;
			default: ;
		endcase
		r.lvl_x = lvl_x;
		r.lvl_y = lvl_y;
		r.fin = fade_done;
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_delay_in = 16'd0;
			cfg_delay_out = 16'd0;
			cfg_fade_in = 16'd1;
			cfg_fade_out = 16'd1;
			lvl_x = 8'd0;
			lvl_y = 8'd0;
			in_wait = '0;
			out_wait = '0;
			in_left = '0;
			out_left = '0;
			fade_done = 1'b0;
			fader_results_due.delete();
			mismatch_count = 0;
			results_due = 0;
		end else begin
			// Compare a result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				seen = '{channel_value, level_x_out, level_y_out, finished, release_res};
				if (fader_results_due.size() == 0) begin
					$display("%0t: result with none expected, got chan %0d x %0d y %0d fin %0b rel %0b",
						$time, seen.chan, seen.lvl_x, seen.lvl_y, seen.fin, seen.rel);
					mismatch_count++;
				end else begin
					oldest = fader_results_due.pop_front();
					check_field("channel_value", oldest.chan, seen.chan);
					check_field("level_x_out", oldest.lvl_x, seen.lvl_x);
					check_field("level_y_out", oldest.lvl_y, seen.lvl_y);
					check_field("finished", 8'(oldest.fin), 8'(seen.fin));
					check_field("release_res", 8'(oldest.rel), 8'(seen.rel));
				end
			end

			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					tsc_pkg::REG_DELAY_IN:  cfg_delay_in = pwdata[15:0];
					tsc_pkg::REG_DELAY_OUT: cfg_delay_out = pwdata[15:0];
					tsc_pkg::REG_FADE_IN:   cfg_fade_in = pwdata[15:0];
					tsc_pkg::REG_FADE_OUT:  cfg_fade_out = pwdata[15:0];
					default: ;
				endcase
			end

			// Predict the result of an item transfer
			if (in_valid && in_ready) begin
				advance_fader(fresh);
				fader_results_due.push_back(fresh);
			end
			results_due = fader_results_due.size();
		end
	end

endmodule

FILE: verif/tb_timed_split_crossfade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_split_crossfade: stimulus and verdict for the timed split crossfader
// Runs a directed pass over level extremes, saturation, manual levels, the
// finished and release flags and mid-fade total changes, then random phases:
// each sets all four timing registers while idle, mostly starts a fade and mixes
// ticks, channel items and manual levels. Both handshakes idle in short bursts.
// ----------------------------------------------------------------------------
module tb_timed_split_crossfade;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET = 1210;
	localparam int QUIET_FROM = 1100;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              in_valid = 1'b0;
	wire               in_ready;
	logic [2:0]        opcode = '0;
	logic [7:0]        level = '0;
	logic [7:0]        chan_min = '0;
	logic signed [8:0] delta_x = '0;
	logic signed [8:0] delta_y = '0;
	logic [7:0]        target = '0;
	logic              no_fade = 1'b0;
	wire               out_valid;
	logic              out_ready = 1'b0;
	wire  [7:0]        channel_value;
	wire  [7:0]        level_x_out;
	wire  [7:0]        level_y_out;
	wire               finished;
	wire               release_res;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	wire  [31:0]       prdata;
	wire               pready;

	int mismatch_count;
	int results_due;
	int items_sent = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	timed_split_crossfade dut (.*);

	tsc_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .level(level),
		.chan_min(chan_min), .delta_x(delta_x), .delta_y(delta_y), .target(target),
		.no_fade(no_fade),
		.out_valid(out_valid), .out_ready(out_ready), .channel_value(channel_value),
		.level_x_out(level_x_out), .level_y_out(level_y_out), .finished(finished),
		.release_res(release_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatch_count(mismatch_count), .results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result channel in short bursts, never in the quiet tail
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready = 1'b1;
		end
	end

	// End the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timed_split_crossfade test failed");
			$finish;
		end
	end

	// Present one item and hold it until the transfer; called at a falling edge
	task automatic send_item(input logic [2:0] op, input logic [7:0] lvl,
			input logic [7:0] cmin, input logic signed [8:0] dx,
			input logic signed [8:0] dy, input logic [7:0] tgt, input logic nf);
		if (!quiet && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) @(negedge clk);
		opcode = op;
		level = lvl;
		chan_min = cmin;
		delta_x = dx;
		delta_y = dy;
		target = tgt;
		no_fade = nf;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
		items_sent++;
	endtask

	// Register write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Hold until every predicted result has been transferred
	task automatic drain_results();
		while (results_due != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [8:0] rand_span();
		int v;
		v = int'($urandom_range(0, 510)) - 255;
		return v[8:0];
	endfunction

	function automatic logic [15:0] rand_delay();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 8));
		endcase
	endfunction

	function automatic logic [15:0] rand_fade_total();
		case ($urandom_range(0, 19))
			0, 1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(1, 65535));
			4: return 16'd0;
			default: return 16'($urandom_range(1, 12));
		endcase
	endfunction

	// Random item, mostly ticks and channels, with all fields randomized
	task automatic send_random_item();
		int pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			op = tsc_pkg::OP_TICK;
		else if (pick < 80)
			op = tsc_pkg::OP_CHAN;
		else if (pick < 85)
			op = tsc_pkg::OP_START;
		else if (pick < 90)
			op = tsc_pkg::OP_SET_X;
		else if (pick < 95)
			op = tsc_pkg::OP_SET_Y;
		else
			op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rand_span(),
			rand_span(), 8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
	endtask

	initial begin
		int phase_len;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Levels at zero: channel gives its base
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd0, 9'sd255, -9'sd255, 8'd0, 1'b0);
		// Saturate high with both levels at full scale
		send_item(tsc_pkg::OP_SET_X, 8'd255, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_SET_Y, 8'd255, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd255, 9'sd255, 9'sd255, 8'd0, 1'b0);
		// Saturate low with both spans negative
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd0, -9'sd255, -9'sd255, 8'd0, 1'b0);
		// Truncation toward zero on a negative quotient
		send_item(tsc_pkg::OP_SET_X, 8'd100, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd10, -9'sd7, -9'sd200, 8'd0, 1'b0);
		// Snap to target at both extremes
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd255, 1'b1);
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd255, 9'sd255, 9'sd255, 8'd0, 1'b1);
		// Unused opcodes change nothing
		send_item(OP_UNUSED_LO, 8'd255, 8'd255, 9'sd255, 9'sd255, 8'd255, 1'b1);
		send_item(OP_UNUSED_MID, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(OP_UNUSED_HI, 8'd170, 8'd85, -9'sd1, 9'sd1, 8'd170, 1'b0);
		// One-tick fade finishes; channel then releases; manual level keeps it sticky
		send_item(tsc_pkg::OP_START, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_TICK, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_CHAN, 8'd0, 8'd20, 9'sd100, 9'sd100, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_SET_X, 8'd37, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_TICK, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		send_item(tsc_pkg::OP_START, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		drain_results();

		// Split delays, then change both totals mid-fade: zero jumps, smaller caps
		write_reg(tsc_pkg::REG_DELAY_IN, 16'd2);
		write_reg(tsc_pkg::REG_DELAY_OUT, 16'd0);
		write_reg(tsc_pkg::REG_FADE_IN, 16'd6);
		write_reg(tsc_pkg::REG_FADE_OUT, 16'd5);
		send_item(tsc_pkg::OP_START, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		repeat (3)
			send_item(tsc_pkg::OP_TICK, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);
		drain_results();
		write_reg(tsc_pkg::REG_FADE_OUT, 16'd0);
		write_reg(tsc_pkg::REG_FADE_IN, 16'd1);
		repeat (3)
			send_item(tsc_pkg::OP_TICK, 8'd0, 8'd0, 9'sd0, 9'sd0, 8'd0, 1'b0);

		// Random phases: new timing while idle, then a fade with mixed traffic
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			write_reg(tsc_pkg::REG_DELAY_IN, rand_delay());
			write_reg(tsc_pkg::REG_DELAY_OUT, rand_delay());
			write_reg(tsc_pkg::REG_FADE_IN, rand_fade_total());
			write_reg(tsc_pkg::REG_FADE_OUT, rand_fade_total());
			if ($urandom_range(0, 9) != 0)
				send_item(tsc_pkg::OP_START, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), rand_span(), rand_span(),
					8'($urandom_range(0, 255)), 1'b0);
			phase_len = $urandom_range(40, 80);
			repeat (phase_len) begin
				quiet = (items_sent >= QUIET_FROM);
				send_random_item();
			end
		end

		drain_results();
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("timed_split_crossfade test passed");
		else
			$display("timed_split_crossfade test failed");
		$finish;
	end

endmodule
